FILE: rtl/core/pixel_format_blit_defines.svh
// assertion macros for the pixel format blit
// used by the top level only; no other dependencies
`ifndef PIXEL_FORMAT_BLIT_DEFINES_SVH
`define PIXEL_FORMAT_BLIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PFB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pixel_format_blit: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define PFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pixel_format_blit: next-cycle check failed");

`endif

FILE: rtl/core/pfb_pkg.sv
// shared types and constants for the pixel format blit
// no dependencies
`default_nettype none

package pfb_pkg;

    localparam int PFB_MAX_DIM = 4096;
    localparam int ADDR_W      = 26;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 88;

    // pixel format codes
    localparam logic [1:0] FMT_A8    = 2'd0;
    localparam logic [1:0] FMT_RGB8  = 2'd1;
    localparam logic [1:0] FMT_RGBA8 = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEST_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FORMAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PITCH  = 3'd7;

    typedef struct packed {
        logic [1:0]  dest_format;
        logic [1:0]  src_format;
        logic        swap_red_blue;
        logic [12:0] surface_width;
        logic [11:0] dest_left;
        logic [11:0] dest_top;
        logic [12:0] rect_width;
        logic [12:0] source_pitch;
    } pfb_cfg_t;

    // one classified pixel as it travels from front to back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       last;
        logic [1:0] sf;
        logic [1:0] df;
    } pfb_pix_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } pfb_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/core/pfb_queue.sv
// short flip-flop queue between front and back of the pixel format blit
// depends on pfb_pkg
`default_nettype none

module pfb_queue import pfb_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data,
    output pfb_qstat_t             stat
);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign stat.count = count_reg;
    assign stat.full  = !in_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pfb_front.sv
// front end of the pixel format blit: rectangle position counters and
// format classification of each accepted item; depends on pfb_pkg
`default_nettype none

module pfb_front import pfb_pkg::*; #(
    parameter int MAX_DIM = PFB_MAX_DIM,
    localparam int CW = $clog2(MAX_DIM)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pfb_cfg_t             cfg,
    input  wire logic                 in_accept,
    input  wire logic [IN_DATA_W-1:0] in_data,
    input  wire logic                 in_last,
    output pfb_pix_t                  pix,
    output logic [CW-1:0]             row,
    output logic [CW-1:0]             col
);

    localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [EW-1:0] eff_w;
    logic [EW-1:0] col_inc;

    assign row = row_reg;
    assign col = col_reg;

    always_comb begin
        pix.b0   = in_data[7:0];
        pix.b1   = in_data[15:8];
        pix.b2   = in_data[23:16];
        pix.b3   = in_data[31:24];
        pix.last = in_last;
        // unused source code behaves as rgba8, unused dest code as alpha8
        if (cfg.src_format == FMT_A8 || cfg.src_format == FMT_RGB8) begin
            pix.sf = cfg.src_format;
        end else begin
            pix.sf = FMT_RGBA8;
        end
        if (cfg.dest_format == FMT_RGB8 || cfg.dest_format == FMT_RGBA8) begin
            pix.df = cfg.dest_format;
        end else begin
            pix.df = FMT_A8;
        end
    end

    always_comb begin
        if (cfg.rect_width == '0) begin
            eff_w = EW'(1);
        end else if (EW'(cfg.rect_width) > EW'(MAX_DIM)) begin
            eff_w = EW'(MAX_DIM);
        end else begin
            eff_w = EW'(cfg.rect_width);
        end
        col_inc  = EW'(col_reg) + EW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept) begin
            if (in_last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= eff_w) begin
                col_next = '0;
                row_next = (row_reg == CW'(MAX_DIM - 1)) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pfb_back.sv
// back end of the pixel format blit: address products, premultiply,
// byte conversion and the output register; depends on pfb_pkg
`default_nettype none

module pfb_back import pfb_pkg::*; #(
    parameter int MAX_DIM = PFB_MAX_DIM,
    localparam int CW = $clog2(MAX_DIM)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire pfb_cfg_t        cfg,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire pfb_pix_t        q_pix,
    input  wire logic [CW-1:0]   q_row,
    input  wire logic [CW-1:0]   q_col,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [OUT_DATA_W-1:0] m_data,
    output logic                 m_last
);

    localparam int TW = ((CW > 12) ? CW : 12) + 1;

    logic                  adv;
    logic                  s1_valid_reg, s1_valid_next;
    pfb_pix_t              s1_pix_reg;
    logic [ADDR_W-1:0]     s1_wbase_reg, s1_woff_reg, s1_rbase_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [7:0]            s1_p0_reg, s1_p1_reg, s1_p2_reg;

    logic [TW-1:0]         top_sum;
    logic [15:0]           prod0, prod1, prod2;

    logic [ADDR_W-1:0]     wpix, rpix, waddr, raddr;
    logic [7:0]            o0, o1, o2, o3;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_last_reg;

    // whole back pipeline moves together when the output slot frees up
    assign adv     = !m_valid_reg || m_ready;
    assign q_ready = adv;

    assign top_sum = TW'(cfg.dest_top) + TW'(q_row);
    assign prod0   = q_pix.b0 * q_pix.b3;
    assign prod1   = q_pix.b1 * q_pix.b3;
    assign prod2   = q_pix.b2 * q_pix.b3;

    assign s1_valid_next = adv ? q_valid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pix_reg   <= q_pix;
            s1_col_reg   <= q_col;
            s1_wbase_reg <= ADDR_W'(top_sum * cfg.surface_width);
            s1_woff_reg  <= ADDR_W'(cfg.dest_left) + ADDR_W'(q_col);
            s1_rbase_reg <= ADDR_W'(q_row * cfg.source_pitch);
            s1_p0_reg    <= prod0[15:8];
            s1_p1_reg    <= prod1[15:8];
            s1_p2_reg    <= prod2[15:8];
        end
    end

    // stage two: finish addresses, scale by bytes per pixel
    always_comb begin
        wpix = s1_wbase_reg + s1_woff_reg;
        rpix = s1_rbase_reg + ADDR_W'(s1_col_reg);
        unique case (s1_pix_reg.df)
            FMT_RGB8:  waddr = (wpix << 1) + wpix;
            FMT_RGBA8: waddr = wpix << 2;
            default:   waddr = wpix;
        endcase
        unique case (s1_pix_reg.sf)
            FMT_A8:   raddr = rpix;
            FMT_RGB8: raddr = (rpix << 1) + rpix;
            default:  raddr = rpix << 2;
        endcase
    end

    // byte conversion
    always_comb begin
        o0 = '0;
        o1 = '0;
        o2 = '0;
        o3 = '0;
        unique case (s1_pix_reg.df)
            FMT_RGB8: begin
                if (s1_pix_reg.sf == FMT_A8) begin
                    o0 = s1_pix_reg.b0;
                    o1 = s1_pix_reg.b0;
                    o2 = s1_pix_reg.b0;
                end else begin
                    o0 = s1_pix_reg.b0;
                    o1 = s1_pix_reg.b1;
                    o2 = s1_pix_reg.b2;
                end
            end
            FMT_RGBA8: begin
                if (s1_pix_reg.sf == FMT_A8) begin
                    o0 = s1_pix_reg.b0;
                    o1 = s1_pix_reg.b0;
                    o2 = s1_pix_reg.b0;
                    o3 = s1_pix_reg.b0;
                end else if (s1_pix_reg.sf == FMT_RGB8) begin
                    o0 = s1_pix_reg.b0;
                    o1 = s1_pix_reg.b1;
                    o2 = s1_pix_reg.b2;
                    o3 = 8'hFF;
                end else begin
                    o0 = s1_p0_reg;
                    o1 = s1_p1_reg;
                    o2 = s1_p2_reg;
                    o3 = s1_pix_reg.b3;
                end
            end
            default: begin
                o0 = (s1_pix_reg.sf == FMT_RGBA8) ? s1_pix_reg.b3 : s1_pix_reg.b0;
            end
        endcase
        if (s1_pix_reg.df != FMT_A8 && cfg.swap_red_blue) begin
            {o0, o2} = {o2, o0};
        end
    end

    assign m_valid_next = adv ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {4'b0000, o3, o2, o1, o0, raddr, waddr};
            m_last_reg <= s1_pix_reg.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pixel_format_blit.sv
// an accepted item passes through the queue, the stage-one register and the output register
// before it is shown on m_axis; throughput one item per cycle while m_axis_tready stays high
// a four-entry queue separates s_axis_tready from m_axis_tready
// aresetn is synchronous, active low: clears counters, queue, stage valids and
// loads every configuration register with its reset value
// depends on pfb_pkg, pfb_front, pfb_queue, pfb_back and the defines header
`default_nettype none
`include "pixel_format_blit_defines.svh"

module pixel_format_blit import pfb_pkg::*; #(
    parameter int MAX_DIM = PFB_MAX_DIM
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // in_byte0 [7:0], in_byte1 [15:8], in_byte2 [23:16], in_byte3 [31:24]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // write_address [25:0], read_address [51:26], out_byte0 [59:52],
    // out_byte1 [67:60], out_byte2 [75:68], out_byte3 [83:76], zero [87:84]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    localparam int CW  = $clog2(MAX_DIM);
    localparam int Q_W = $bits(pfb_pix_t) + 2 * CW;

    pfb_cfg_t       cfg_reg, cfg_next;
    pfb_pix_t       f_pix, q_pix;
    logic [CW-1:0]  f_row, f_col, q_row, q_col;
    logic           q_push, q_pop;
    logic           q_out_valid, q_out_ready;
    logic [Q_W-1:0] q_out_data;
    pfb_qstat_t     q_stat;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_DEST_FORMAT:   cfg_next.dest_format   = cfg_wdata[1:0];
                REG_SRC_FORMAT:    cfg_next.src_format    = cfg_wdata[1:0];
                REG_SWAP_RED_BLUE: cfg_next.swap_red_blue = cfg_wdata[0];
                REG_SURFACE_WIDTH: cfg_next.surface_width = cfg_wdata[12:0];
                REG_DEST_LEFT:     cfg_next.dest_left     = cfg_wdata[11:0];
                REG_DEST_TOP:      cfg_next.dest_top      = cfg_wdata[11:0];
                REG_RECT_WIDTH:    cfg_next.rect_width    = cfg_wdata[12:0];
                REG_SOURCE_PITCH:  cfg_next.source_pitch  = cfg_wdata[12:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_format   <= FMT_RGBA8;
            cfg_reg.src_format    <= FMT_RGBA8;
            cfg_reg.swap_red_blue <= 1'b0;
            cfg_reg.surface_width <= 13'd1;
            cfg_reg.dest_left     <= '0;
            cfg_reg.dest_top      <= '0;
            cfg_reg.rect_width    <= 13'd1;
            cfg_reg.source_pitch  <= 13'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign q_push = s_axis_tvalid && s_axis_tready;
    assign q_pop  = q_out_valid && q_out_ready;

    pfb_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_accept(q_push),
        .in_data  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .pix      (f_pix),
        .row      (f_row),
        .col      (f_col)
    );

    pfb_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  ({f_pix, f_row, f_col}),
        .out_valid(q_out_valid),
        .out_ready(q_out_ready),
        .out_data (q_out_data),
        .stat     (q_stat)
    );

    assign {q_pix, q_row, q_col} = q_out_data;

    pfb_back #(
        .MAX_DIM(MAX_DIM)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_out_valid),
        .q_ready (q_out_ready),
        .q_pix   (q_pix),
        .q_row   (q_row),
        .q_col   (q_col),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

    // a final item sends the rectangle position back to its origin
    `PFB_ASSERT_NEXT(a_last_clears_pos, aclk, aresetn, q_push && s_axis_tlast, (f_row == '0) && (f_col == '0))
    // row counter wraps before reaching the maximum dimension
    `PFB_ASSERT_SAME(a_row_in_range, aclk, aresetn, 1'b1, f_row <= CW'(MAX_DIM - 1))
    // queue fill only moves on a push or a pop
    `PFB_ASSERT_NEXT(a_queue_count_hold, aclk, aresetn, !q_push && !q_pop, $stable(q_stat.count))

endmodule

`default_nettype wire
